// File: hdl/assert_macros.svh
// Assertion macros shared by the ray/triangle intersection RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define RTI_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rti assertion failed");

// Check a property on every clock edge, reset included.
`define RTI_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("rti assertion failed");

`else

`define RTI_ASSERT(name, clk, rst_n, prop)
`define RTI_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: hdl/rti_pkg.sv
// Package for the ray/triangle intersection block: widths, constants,
// payload structs and the register index codes. Depends on nothing.
package rti_pkg;

    // Fixed formats
    localparam int COORD_W     = 24;
    localparam int COORD_FRAC  = 12;
    localparam int RESULT_FRAC = 16;

    // Derived arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CRS_W   = 2 * COORD_W + 2;
    localparam int SPLIT_W = COORD_W + 1;
    localparam int LO_W    = DIFF_W + SPLIT_W + 1;
    localparam int HI_W    = DIFF_W + CRS_W - SPLIT_W;
    localparam int HSUM_W  = HI_W + 2;
    localparam int LSUM_W  = LO_W + 2;
    localparam int DOT_W   = HSUM_W + SPLIT_W;
    localparam int OUT_W   = 32;
    localparam int QUO_W   = OUT_W - 1;
    localparam int REM_W   = DOT_W + OUT_W;
    localparam int PROD_W  = OUT_W + COORD_W;
    localparam int HP_W    = PROD_W + 1;

    localparam longint unsigned DET_TOL =
        ((64'd1 << (3 * COORD_FRAC)) + 64'd99999) / 64'd100000;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));

    // Pipeline shape
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FRONT_STAGES = 7;
    localparam int DIV_STAGES   = QUO_W + 1;
    localparam int BACK_TAIL    = 3;
    localparam int LATENCY      = FRONT_STAGES + 1 + DIV_STAGES + BACK_TAIL;

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_CULL
    } reg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [CRS_W-1:0]   crs_t;
    typedef logic signed [LO_W-1:0]    lo_t;
    typedef logic signed [HI_W-1:0]    hi_t;
    typedef logic signed [HSUM_W-1:0]  hsum_t;
    typedef logic signed [LSUM_W-1:0]  lsum_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [DOT_W:0]     st_t;
    typedef logic        [DOT_W-1:0]   mag_t;
    typedef logic        [REM_W-1:0]   rem_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [HP_W-1:0]    hp_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
        logic signed [COORD_W-1:0] v3_x;
        logic signed [COORD_W-1:0] v3_y;
        logic signed [COORD_W-1:0] v3_z;
    } rti_tri_t;

    typedef struct packed {
        logic                      hit;
        logic signed [OUT_W-1:0]   ray_distance;
        logic signed [OUT_W-1:0]   bary_s;
        logic signed [OUT_W-1:0]   bary_t;
        logic signed [COORD_W-1:0] hit_point_x;
        logic signed [COORD_W-1:0] hit_point_y;
        logic signed [COORD_W-1:0] hit_point_z;
    } rti_result_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] org;
        logic [2:0][COORD_W-1:0] dir;
        logic                    cull;
    } rti_cfg_t;

    // Classified triangle handed from front to back
    typedef struct packed {
        logic hit;
        mag_t den;
        mag_t num_r;
        mag_t num_s;
        mag_t num_t;
    } rti_job_t;

endpackage

// File: hdl/ray_triangle_intersect.sv
// Ray/triangle intersection top level: configuration registers, front end,
// queue and back end. Depends on rti_pkg, rti_front, rti_queue, rti_back.
//
// Set the ray origin, direction and back-face cull flag through the cfg
// channel (index 0..2 origin x/y/z, 3..5 direction x/y/z, 6 cull; any other
// index is ignored; cfg_ready is always high) while no triangle is in flight.
// Then issue one triangle per clock: a transfer happens on every edge with
// start high and busy low. Each triangle yields exactly one result, in issue
// order. For each transferred triangle done is high for a single cycle, and
// the result is on result and transfers in that cycle. The receiver cannot
// hold results off, so capture result whenever done is high. Throughput is
// one triangle per cycle while busy is low: the front end is a 7-stage
// multiply/add pipeline, each triangle passes through the queue, and
// the back end runs three 32-stage restoring dividers (a scaling stage, then
// one quotient bit per stage) followed by a 3-stage tail for the hit point.
// Busy only rises once the queue between the halves holds three entries,
// which the non-stalling back end never lets happen. On a miss every result
// field is zero; on a hit the quotients are non-negative and saturate at
// 2^31-1, and the hit point saturates to the coordinate range.
`include "assert_macros.svh"

module ray_triangle_intersect import rti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rti_tri_t             triangle,
    output logic                 done,
    output rti_result_t          result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    rti_cfg_t          cfg_reg;
    logic              accept;
    logic              front_valid;
    rti_job_t          front_job;
    logic              q_valid;
    rti_job_t          q_job;
    logic              back_take;
    logic [QCNT_W-1:0] q_level;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    // Hold off new triangles once the queue is close to full
    assign busy      = q_level >= QCNT_W'(QUEUE_DEPTH - 1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            cfg_reg.dir[0] <= COORD_W'(1 << COORD_FRAC);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ORG_X: cfg_reg.org[0] <= cfg_data;
                REG_ORG_Y: cfg_reg.org[1] <= cfg_data;
                REG_ORG_Z: cfg_reg.org[2] <= cfg_data;
                REG_DIR_X: cfg_reg.dir[0] <= cfg_data;
                REG_DIR_Y: cfg_reg.dir[1] <= cfg_data;
                REG_DIR_Z: cfg_reg.dir[2] <= cfg_data;
                REG_CULL:  cfg_reg.cull   <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // Front end: edges, determinant, unnormalised s/t/r and the hit test
    rti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .item      (triangle),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .job       (front_job)
    );

    // Decouple the two halves
    rti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .din       (front_job),
        .take      (back_take),
        .out_valid (q_valid),
        .dout      (q_job),
        .level     (q_level)
    );

    // Back end: divisions and hit point
    rti_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .job      (q_job),
        .cfg      (cfg_reg),
        .take     (back_take),
        .done     (done),
        .result   (result)
    );

    `RTI_ASSERT(a_done_follows_transfer, clk, rst_n, done |-> $past(accept, LATENCY))
    `RTI_ASSERT(a_miss_is_zero, clk, rst_n, (done && !result.hit) |-> (result.ray_distance == '0 && result.bary_s == '0 && result.bary_t == '0 && result.hit_point_x == '0 && result.hit_point_y == '0 && result.hit_point_z == '0))
    `RTI_ASSERT(a_hit_quotients_nonneg, clk, rst_n, (done && result.hit) |-> (!result.ray_distance[OUT_W-1] && !result.bary_s[OUT_W-1] && !result.bary_t[OUT_W-1]))

endmodule

// File: hdl/rti_front.sv
// Front end: edges, cross products, the four dot products and the hit test.
// Depends on rti_pkg. Seven register stages, one triangle per cycle.
module rti_front import rti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  rti_tri_t item,
    input  rti_cfg_t cfg,
    output logic     out_valid,
    output rti_job_t job
);

    localparam int D_DET = 0;
    localparam int D_S   = 1;
    localparam int D_T   = 2;
    localparam int D_R   = 3;

    coord_t va [3];
    coord_t vb [3];
    coord_t vc [3];
    coord_t org [3];
    coord_t dir [3];

    diff_t e1_s1_reg [3];
    diff_t e2_s1_reg [3];
    diff_t sv_s1_reg [3];
    crs_t  pa_s2_reg [3];
    crs_t  pb_s2_reg [3];
    crs_t  qa_s2_reg [3];
    crs_t  qb_s2_reg [3];
    diff_t e1_s2_reg [3];
    diff_t e2_s2_reg [3];
    diff_t sv_s2_reg [3];
    crs_t  p_s3_reg  [3];
    crs_t  q_s3_reg  [3];
    diff_t e1_s3_reg [3];
    diff_t e2_s3_reg [3];
    diff_t sv_s3_reg [3];
    lo_t   lo_s4_reg [4][3];
    hi_t   hi_s4_reg [4][3];
    hsum_t hsum_s5_reg [4];
    lsum_t lsum_s5_reg [4];
    dot_t  dot_s6_reg  [4];

    logic [FRONT_STAGES-1:0] vld_reg;
    rti_job_t job_reg;
    rti_job_t job_next;

    function automatic lo_t lo_part(diff_t a, crs_t c);
        lo_t res;
        res = a * $signed({1'b0, c[SPLIT_W-1:0]});
        return res;
    endfunction

    function automatic hi_t hi_part(diff_t a, crs_t c);
        hi_t res;
        res = a * $signed(c[CRS_W-1:SPLIT_W]);
        return res;
    endfunction

    always_comb
    begin
        va[0] = item.v1_x; va[1] = item.v1_y; va[2] = item.v1_z;
        vb[0] = item.v2_x; vb[1] = item.v2_y; vb[2] = item.v2_z;
        vc[0] = item.v3_x; vc[1] = item.v3_y; vc[2] = item.v3_z;
        for (int i = 0; i < 3; i++)
        begin
            org[i] = $signed(cfg.org[i]);
            dir[i] = $signed(cfg.dir[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_axis
            localparam int J = (gi + 1) % 3;
            localparam int K = (gi + 2) % 3;

            always_ff @(posedge clk)
            begin
                // edges and origin offset
                e1_s1_reg[gi] <= diff_t'(vc[gi]) - diff_t'(va[gi]);
                e2_s1_reg[gi] <= diff_t'(vb[gi]) - diff_t'(va[gi]);
                sv_s1_reg[gi] <= diff_t'(org[gi]) - diff_t'(va[gi]);

                // cross product terms: P = dir x E2, Q = S x E1
                pa_s2_reg[gi] <= diff_t'(dir[J]) * e2_s1_reg[K];
                pb_s2_reg[gi] <= diff_t'(dir[K]) * e2_s1_reg[J];
                qa_s2_reg[gi] <= sv_s1_reg[J] * e1_s1_reg[K];
                qb_s2_reg[gi] <= sv_s1_reg[K] * e1_s1_reg[J];
                e1_s2_reg[gi] <= e1_s1_reg[gi];
                e2_s2_reg[gi] <= e2_s1_reg[gi];
                sv_s2_reg[gi] <= sv_s1_reg[gi];

                p_s3_reg[gi]  <= pa_s2_reg[gi] - pb_s2_reg[gi];
                q_s3_reg[gi]  <= qa_s2_reg[gi] - qb_s2_reg[gi];
                e1_s3_reg[gi] <= e1_s2_reg[gi];
                e2_s3_reg[gi] <= e2_s2_reg[gi];
                sv_s3_reg[gi] <= sv_s2_reg[gi];

                // dot product terms, split into high and low partial products
                lo_s4_reg[D_DET][gi] <= lo_part(e1_s3_reg[gi], p_s3_reg[gi]);
                hi_s4_reg[D_DET][gi] <= hi_part(e1_s3_reg[gi], p_s3_reg[gi]);
                lo_s4_reg[D_S][gi]   <= lo_part(sv_s3_reg[gi], p_s3_reg[gi]);
                hi_s4_reg[D_S][gi]   <= hi_part(sv_s3_reg[gi], p_s3_reg[gi]);
                lo_s4_reg[D_T][gi]   <= lo_part(diff_t'(dir[gi]), q_s3_reg[gi]);
                hi_s4_reg[D_T][gi]   <= hi_part(diff_t'(dir[gi]), q_s3_reg[gi]);
                lo_s4_reg[D_R][gi]   <= lo_part(e2_s3_reg[gi], q_s3_reg[gi]);
                hi_s4_reg[D_R][gi]   <= hi_part(e2_s3_reg[gi], q_s3_reg[gi]);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
        begin
            hsum_s5_reg[d] <= hsum_t'(hi_s4_reg[d][0]) + hsum_t'(hi_s4_reg[d][1])
                            + hsum_t'(hi_s4_reg[d][2]);
            lsum_s5_reg[d] <= lsum_t'(lo_s4_reg[d][0]) + lsum_t'(lo_s4_reg[d][1])
                            + lsum_t'(lo_s4_reg[d][2]);
            dot_s6_reg[d]  <= (dot_t'(hsum_s5_reg[d]) <<< SPLIT_W)
                            + dot_t'(lsum_s5_reg[d]);
        end
        job_reg <= job_next;
    end

    // Hit test, mirrored for the sign of the determinant
    always_comb
    begin
        dot_t det;
        dot_t s;
        dot_t t;
        dot_t r;
        dot_t tol;
        st_t  st;
        st_t  det_x;
        logic pos;
        logic neg_ok;
        logic pos_pass;
        logic neg_pass;

        det    = dot_s6_reg[D_DET];
        s      = dot_s6_reg[D_S];
        t      = dot_s6_reg[D_T];
        r      = dot_s6_reg[D_R];
        tol    = dot_t'(DET_TOL);
        st     = st_t'(s) + st_t'(t);
        det_x  = st_t'(det);
        pos    = det >= tol;
        neg_ok = (det <= -tol) && !cfg.cull;

        pos_pass = !(s[DOT_W-1] || (s > det) || t[DOT_W-1] || (st > det_x)
                     || r[DOT_W-1]);
        neg_pass = !((s > 0) || (s < det) || (t > 0) || (st < det_x) || (r > 0));

        job_next.hit   = pos ? pos_pass : (neg_ok && neg_pass);
        job_next.den   = pos ? mag_t'(det) : mag_t'(-det);
        job_next.num_s = pos ? mag_t'(s)   : mag_t'(-s);
        job_next.num_t = pos ? mag_t'(t)   : mag_t'(-t);
        job_next.num_r = pos ? mag_t'(r)   : mag_t'(-r);
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign job       = job_reg;

endmodule

// File: hdl/rti_queue.sv
// Short queue between front and back ends for classified triangles.
// Depends on rti_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rti_queue import rti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rti_job_t          din,
    input  logic              take,
    output logic              out_valid,
    output rti_job_t          dout,
    output logic [QCNT_W-1:0] level
);

    rti_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && take;
    assign dout      = mem_reg[rd_ptr_reg];
    assign level     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `RTI_ASSERT(a_no_overflow, clk, rst_n, !(push && !pop && count_reg == QCNT_W'(QUEUE_DEPTH)))
    `RTI_ASSERT_ALWAYS(a_count_range, clk, count_reg <= QCNT_W'(QUEUE_DEPTH))

endmodule

// File: hdl/rti_div.sv
// Pipelined restoring divider lane: floor(num * 2^RESULT_FRAC / den),
// saturated to 2^31-1, one quotient bit per stage. Depends on rti_pkg.
module rti_div import rti_pkg::*;
(
    input  logic clk,
    input  mag_t num,
    input  mag_t den,
    output quo_t quo
);

    rem_t rem_reg [DIV_STAGES];
    mag_t den_reg [DIV_STAGES];
    quo_t q_reg   [DIV_STAGES];
    logic sat_reg [DIV_STAGES];

    // Scale the numerator and flag quotients that would not fit
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_t'(num) << RESULT_FRAC;
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        sat_reg[0] <= rem_t'(num) >= (rem_t'(den) << (QUO_W - RESULT_FRAC));
    end

    genvar gk;
    generate
        for (gk = 1; gk < DIV_STAGES; gk++)
        begin : g_step
            localparam int B = QUO_W - gk;
            rem_t trial;
            logic ge;

            assign trial = rem_t'(den_reg[gk-1]) << B;
            assign ge    = rem_reg[gk-1] >= trial;

            always_ff @(posedge clk)
            begin
                rem_reg[gk] <= ge ? rem_reg[gk-1] - trial : rem_reg[gk-1];
                den_reg[gk] <= den_reg[gk-1];
                q_reg[gk]   <= q_reg[gk-1] | (quo_t'(ge) << B);
                sat_reg[gk] <= sat_reg[gk-1];
            end
        end
    endgenerate

    assign quo = sat_reg[DIV_STAGES-1] ? '1 : q_reg[DIV_STAGES-1];

endmodule

// File: hdl/rti_back.sv
// Back end: three divider lanes for r, s and t, then the hit point
// origin + r*dir with saturation. Depends on rti_pkg and rti_div.
module rti_back import rti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  rti_job_t    job,
    input  rti_cfg_t    cfg,
    output logic        take,
    output logic        done,
    output rti_result_t result
);

    quo_t quo_r;
    quo_t quo_s;
    quo_t quo_t_w;

    logic vld_line_reg [DIV_STAGES];
    logic hit_line_reg [DIV_STAGES];

    quo_t rs_m1_reg;
    quo_t ss_m1_reg;
    quo_t ts_m1_reg;
    logic vld_m1_reg;
    logic hit_m1_reg;

    prod_t prod_m2_reg [3];
    quo_t  rs_m2_reg;
    quo_t  ss_m2_reg;
    quo_t  ts_m2_reg;
    logic  vld_m2_reg;
    logic  hit_m2_reg;

    rti_result_t result_reg;
    rti_result_t result_next;
    logic        done_reg;
    coord_t      hp [3];

    // The back end never stalls
    assign take = 1'b1;

    rti_div u_div_r (.clk(clk), .num(job.num_r), .den(job.den), .quo(quo_r));
    rti_div u_div_s (.clk(clk), .num(job.num_s), .den(job.den), .quo(quo_s));
    rti_div u_div_t (.clk(clk), .num(job.num_t), .den(job.den), .quo(quo_t_w));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                vld_line_reg[k] <= 1'b0;
            end
            vld_m1_reg <= 1'b0;
            vld_m2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vld_line_reg[0] <= in_valid;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                vld_line_reg[k] <= vld_line_reg[k-1];
            end
            vld_m1_reg <= vld_line_reg[DIV_STAGES-1];
            vld_m2_reg <= vld_m1_reg;
            done_reg   <= vld_m2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_line_reg[0] <= job.hit;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            hit_line_reg[k] <= hit_line_reg[k-1];
        end

        rs_m1_reg  <= quo_r;
        ss_m1_reg  <= quo_s;
        ts_m1_reg  <= quo_t_w;
        hit_m1_reg <= hit_line_reg[DIV_STAGES-1];

        for (int i = 0; i < 3; i++)
        begin
            prod_m2_reg[i] <= $signed({1'b0, rs_m1_reg}) * $signed(cfg.dir[i]);
        end
        rs_m2_reg  <= rs_m1_reg;
        ss_m2_reg  <= ss_m1_reg;
        ts_m2_reg  <= ts_m1_reg;
        hit_m2_reg <= hit_m1_reg;

        result_reg <= result_next;
    end

    // Floor the product, add the origin, clamp to the coordinate range
    always_comb
    begin
        hp_t sum;
        for (int i = 0; i < 3; i++)
        begin
            sum = hp_t'($signed(cfg.org[i])) + hp_t'(prod_m2_reg[i] >>> RESULT_FRAC);
            if (sum > hp_t'(COORD_MAX))
            begin
                hp[i] = coord_t'(COORD_MAX);
            end
            else if (sum < hp_t'(COORD_MIN))
            begin
                hp[i] = coord_t'(COORD_MIN);
            end
            else
            begin
                hp[i] = sum[COORD_W-1:0];
            end
        end

        result_next = '0;
        if (hit_m2_reg)
        begin
            result_next.hit          = 1'b1;
            result_next.ray_distance = {1'b0, rs_m2_reg};
            result_next.bary_s       = {1'b0, ss_m2_reg};
            result_next.bary_t       = {1'b0, ts_m2_reg};
            result_next.hit_point_x  = hp[0];
            result_next.hit_point_y  = hp[1];
            result_next.hit_point_z  = hp[2];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
